// File: rtl/a2e_pkg.sv
// ----------------------------------------------------------------------------
// a2e_pkg - shared types and constants for the ASN.1 time to epoch converter
// Holds the transaction structs, the parse phase enum, the error codes, the
// character codes and the cumulative month table.
// ----------------------------------------------------------------------------
package a2e_pkg;

	// Input transaction: one character of the time string
	typedef struct packed {
		logic [7:0] char_byte;
		logic [1:0] string_type;
		logic       last_char;
	} a2e_item_t;

	// Result transaction: signed Unix seconds and an error code
	typedef struct packed {
		logic signed [38:0] epoch_seconds;
		logic [1:0]         error_code;
	} a2e_result_t;

	// Error codes
	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_MALFORMED = 2'd1,
		ERR_RANGE     = 2'd2,
		ERR_NO_ZONE   = 2'd3
	} a2e_err_t;

	// Parse phases of the character scanner
	typedef enum logic [4:0] {
		PH_START   = 5'd0,
		PH_GY2     = 5'd1,
		PH_GY3     = 5'd2,
		PH_GY4     = 5'd3,
		PH_UY2     = 5'd4,
		PH_MO1     = 5'd5,
		PH_MO2     = 5'd6,
		PH_DA1     = 5'd7,
		PH_DA2     = 5'd8,
		PH_HR1     = 5'd9,
		PH_HR2     = 5'd10,
		PH_MI1     = 5'd11,
		PH_MI2     = 5'd12,
		PH_SEC_OPT = 5'd13,
		PH_SEC2    = 5'd14,
		PH_AFTER   = 5'd15,
		PH_ZH1     = 5'd16,
		PH_ZH2     = 5'd17,
		PH_ZM1     = 5'd18,
		PH_ZM2     = 5'd19,
		PH_DONE    = 5'd20,
		PH_FAIL    = 5'd21
	} a2e_phase_t;

	// Classified string handed from the scanner to the epoch pipeline
	typedef struct packed {
		a2e_err_t           code;
		logic [6:0]         cent;    // year / 100
		logic [6:0]         low;     // year % 100
		logic [3:0]         month;
		logic [4:0]         day;
		logic [4:0]         hour;
		logic [5:0]         minute;
		logic [5:0]         second;
		logic signed [10:0] zone;    // offset in minutes, east positive
	} a2e_job_t;

	// String types
	localparam logic [1:0] TYPE_UTC = 2'd0;
	localparam logic [1:0] TYPE_GEN = 2'd1;

	// Character codes
	localparam logic [7:0] CH_0     = 8'd48;
	localparam logic [7:0] CH_9     = 8'd57;
	localparam logic [7:0] CH_Z     = 8'd90;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_DOT   = 8'd46;
	localparam logic [7:0] CH_COMMA = 8'd44;

	// Days before the first of a month in a common year
	function automatic logic [8:0] cum_days(input logic [3:0] month);
		logic [8:0] days;
		begin
			unique case (month)
				4'd2:    days = 9'd31;
				4'd3:    days = 9'd59;
				4'd4:    days = 9'd90;
				4'd5:    days = 9'd120;
				4'd6:    days = 9'd151;
				4'd7:    days = 9'd181;
				4'd8:    days = 9'd212;
				4'd9:    days = 9'd243;
				4'd10:   days = 9'd273;
				4'd11:   days = 9'd304;
				4'd12:   days = 9'd334;
				default: days = 9'd0;
			endcase
			return days;
		end
	endfunction

endpackage

// File: rtl/a2e_queue.sv
// ----------------------------------------------------------------------------
// a2e_queue - small synchronous queue
// Register-based queue with head and tail pointers and a fill count. The head
// entry is shown on rd_data while empty is low. Depth must be 2 or more.
// ----------------------------------------------------------------------------
module a2e_queue #(
	parameter int Width = 8,
	parameter int Depth = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [Width-1:0] wr_data,
	input  logic             rd_en,
	output logic [Width-1:0] rd_data,
	output logic             empty,
	output logic             full
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	logic [Width-1:0] store_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_wr;
	logic             do_rd;

	assign empty   = (count_q == '0);
	assign full    = (count_q == FullCnt);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = store_q[rd_ptr_q];

	// Write the tail entry
	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CntW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

// File: rtl/a2e_front.sv
// ----------------------------------------------------------------------------
// a2e_front - character scanner and classifier
// Walks the time string one character per accepted transaction, checks each
// field, and on the final character hands a classified job to the back end.
// ----------------------------------------------------------------------------
module a2e_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  a2e_pkg::a2e_item_t  item,
	output logic                job_valid,
	output a2e_pkg::a2e_job_t   job
);

	a2e_pkg::a2e_phase_t phase_q, phase_d;
	logic        gen_q, gen_d;
	logic [3:0]  acc_q, acc_d;
	logic [6:0]  cent_q, cent_d;
	logic [6:0]  low_q, low_d;
	logic [3:0]  month_q, month_d;
	logic [4:0]  day_q, day_d;
	logic [4:0]  hour_q, hour_d;
	logic [5:0]  minute_q, minute_d;
	logic [5:0]  second_q, second_d;
	logic [9:0]  zh60_q, zh60_d;
	logic        zneg_q, zneg_d;

	logic        dig;
	logic [3:0]  d;
	logic [6:0]  pair;
	logic        is_z;
	logic        is_sign;
	logic        is_frac;
	logic [10:0] zmag;
	logic signed [10:0] zone_val;

	// Classify the current character
	assign dig     = (item.char_byte >= a2e_pkg::CH_0) && (item.char_byte <= a2e_pkg::CH_9);
	assign d       = dig ? 4'(item.char_byte - a2e_pkg::CH_0) : 4'd0;
	assign pair    = 7'(acc_q) * 7'd10 + 7'(d);
	assign is_z    = (item.char_byte == a2e_pkg::CH_Z);
	assign is_sign = (item.char_byte == a2e_pkg::CH_PLUS) ||
	                 (item.char_byte == a2e_pkg::CH_MINUS);
	assign is_frac = (item.char_byte == a2e_pkg::CH_DOT) ||
	                 (item.char_byte == a2e_pkg::CH_COMMA);

	// Next parse phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			a2e_pkg::PH_START: begin
				if (!dig || (item.string_type > a2e_pkg::TYPE_GEN)) begin
					phase_d = a2e_pkg::PH_FAIL;
				end else begin
					phase_d = (item.string_type == a2e_pkg::TYPE_GEN) ?
					          a2e_pkg::PH_GY2 : a2e_pkg::PH_UY2;
				end
			end
			a2e_pkg::PH_GY2: phase_d = dig ? a2e_pkg::PH_GY3 : a2e_pkg::PH_FAIL;
			a2e_pkg::PH_GY3: phase_d = dig ? a2e_pkg::PH_GY4 : a2e_pkg::PH_FAIL;
			a2e_pkg::PH_GY4: phase_d = dig ? a2e_pkg::PH_MO1 : a2e_pkg::PH_FAIL;
			a2e_pkg::PH_UY2: phase_d = dig ? a2e_pkg::PH_MO1 : a2e_pkg::PH_FAIL;
			a2e_pkg::PH_MO1: phase_d = dig ? a2e_pkg::PH_MO2 : a2e_pkg::PH_FAIL;
			a2e_pkg::PH_MO2: phase_d = (dig && pair >= 7'd1 && pair <= 7'd12) ?
			                           a2e_pkg::PH_DA1 : a2e_pkg::PH_FAIL;
			a2e_pkg::PH_DA1: phase_d = dig ? a2e_pkg::PH_DA2 : a2e_pkg::PH_FAIL;
			a2e_pkg::PH_DA2: phase_d = (dig && pair >= 7'd1 && pair <= 7'd31) ?
			                           a2e_pkg::PH_HR1 : a2e_pkg::PH_FAIL;
			a2e_pkg::PH_HR1: phase_d = dig ? a2e_pkg::PH_HR2 : a2e_pkg::PH_FAIL;
			a2e_pkg::PH_HR2: phase_d = (dig && pair <= 7'd23) ?
			                           a2e_pkg::PH_MI1 : a2e_pkg::PH_FAIL;
			a2e_pkg::PH_MI1: phase_d = dig ? a2e_pkg::PH_MI2 : a2e_pkg::PH_FAIL;
			a2e_pkg::PH_MI2: phase_d = (dig && pair <= 7'd59) ?
			                           a2e_pkg::PH_SEC_OPT : a2e_pkg::PH_FAIL;
			a2e_pkg::PH_SEC_OPT: begin
				priority if (dig) begin
					phase_d = a2e_pkg::PH_SEC2;
				end else if (is_z) begin
					phase_d = a2e_pkg::PH_DONE;
				end else if (is_sign) begin
					phase_d = a2e_pkg::PH_ZH1;
				end else if (gen_q && is_frac) begin
					phase_d = a2e_pkg::PH_AFTER;
				end else begin
					phase_d = a2e_pkg::PH_FAIL;
				end
			end
			a2e_pkg::PH_SEC2: phase_d = (dig && pair <= 7'd59) ?
			                            a2e_pkg::PH_AFTER : a2e_pkg::PH_FAIL;
			a2e_pkg::PH_AFTER: begin
				priority if (is_z) begin
					phase_d = a2e_pkg::PH_DONE;
				end else if (is_sign) begin
					phase_d = a2e_pkg::PH_ZH1;
				end else if (gen_q && (dig || is_frac)) begin
					phase_d = a2e_pkg::PH_AFTER;
				end else begin
					phase_d = a2e_pkg::PH_FAIL;
				end
			end
			a2e_pkg::PH_ZH1: phase_d = dig ? a2e_pkg::PH_ZH2 : a2e_pkg::PH_FAIL;
			a2e_pkg::PH_ZH2: phase_d = (dig && pair <= 7'd12) ?
			                           a2e_pkg::PH_ZM1 : a2e_pkg::PH_FAIL;
			a2e_pkg::PH_ZM1: phase_d = dig ? a2e_pkg::PH_ZM2 : a2e_pkg::PH_FAIL;
			a2e_pkg::PH_ZM2: phase_d = (dig && pair <= 7'd59) ?
			                           a2e_pkg::PH_DONE : a2e_pkg::PH_FAIL;
			default:         phase_d = a2e_pkg::PH_FAIL;
		endcase
	end

	// Field captures for the current phase
	always_comb begin
		gen_d    = gen_q;
		acc_d    = acc_q;
		cent_d   = cent_q;
		low_d    = low_q;
		month_d  = month_q;
		day_d    = day_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		second_d = second_q;
		zh60_d   = zh60_q;
		zneg_d   = zneg_q;
		unique case (phase_q)
			a2e_pkg::PH_START: begin
				gen_d = (item.string_type == a2e_pkg::TYPE_GEN);
				acc_d = d;
			end
			a2e_pkg::PH_GY2: cent_d = pair;
			a2e_pkg::PH_GY4: low_d  = pair;
			a2e_pkg::PH_UY2: begin
				low_d  = pair;
				cent_d = (pair < 7'd50) ? 7'd20 : 7'd19;
			end
			a2e_pkg::PH_GY3, a2e_pkg::PH_MO1, a2e_pkg::PH_DA1, a2e_pkg::PH_HR1,
			a2e_pkg::PH_MI1, a2e_pkg::PH_ZH1, a2e_pkg::PH_ZM1: acc_d = d;
			a2e_pkg::PH_MO2: month_d  = pair[3:0];
			a2e_pkg::PH_DA2: day_d    = pair[4:0];
			a2e_pkg::PH_HR2: hour_d   = pair[4:0];
			a2e_pkg::PH_MI2: minute_d = pair[5:0];
			a2e_pkg::PH_SEC_OPT: begin
				acc_d  = d;
				zneg_d = (item.char_byte == a2e_pkg::CH_MINUS);
			end
			a2e_pkg::PH_SEC2:  second_d = pair[5:0];
			a2e_pkg::PH_AFTER: zneg_d   = (item.char_byte == a2e_pkg::CH_MINUS);
			a2e_pkg::PH_ZH2:   zh60_d   = 10'(pair) * 10'd60;
			default: begin
			end
		endcase
	end

	// Build the zone offset on the last zone digit
	assign zmag     = 11'(zh60_q) + 11'(pair);
	assign zone_val = zneg_q ? -$signed(zmag) : $signed(zmag);

	// Classify the finished string
	assign job_valid = take && item.last_char;
	always_comb begin
		job.cent   = cent_q;
		job.low    = low_q;
		job.month  = month_q;
		job.day    = day_q;
		job.hour   = hour_q;
		job.minute = minute_q;
		job.second = second_q;
		job.zone   = (phase_q == a2e_pkg::PH_ZM2) ? zone_val : 11'sd0;
		priority if (phase_d == a2e_pkg::PH_DONE) begin
			job.code = a2e_pkg::ERR_NONE;
		end else if (gen_d && (phase_d == a2e_pkg::PH_SEC_OPT ||
		                       phase_d == a2e_pkg::PH_AFTER)) begin
			job.code = a2e_pkg::ERR_NO_ZONE;
		end else begin
			job.code = a2e_pkg::ERR_MALFORMED;
		end
	end

	// Hold parse state; clear it after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= a2e_pkg::PH_START;
			gen_q    <= 1'b0;
			acc_q    <= '0;
			cent_q   <= '0;
			low_q    <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			zh60_q   <= '0;
			zneg_q   <= 1'b0;
		end else if (take) begin
			if (item.last_char) begin
				phase_q  <= a2e_pkg::PH_START;
				gen_q    <= 1'b0;
				acc_q    <= '0;
				cent_q   <= '0;
				low_q    <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
				zh60_q   <= '0;
				zneg_q   <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				gen_q    <= gen_d;
				acc_q    <= acc_d;
				cent_q   <= cent_d;
				low_q    <= low_d;
				month_q  <= month_d;
				day_q    <= day_d;
				hour_q   <= hour_d;
				minute_q <= minute_d;
				second_q <= second_d;
				zh60_q   <= zh60_d;
				zneg_q   <= zneg_d;
			end
		end
	end

endmodule

// File: rtl/a2e_back.sv
// ----------------------------------------------------------------------------
// a2e_back - epoch arithmetic pipeline
// Three stages turn a classified job into Unix seconds: year and calendar
// terms, day count, then seconds with the sign check at the output.
// ----------------------------------------------------------------------------
module a2e_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	input  a2e_pkg::a2e_job_t     job,
	output logic                  job_pop,
	input  logic                  out_full,
	output logic                  res_push,
	output a2e_pkg::a2e_result_t  result
);

	logic en;

	// Stage 1 combinational terms
	logic [13:0]        y_d;
	logic               ge_d;
	logic               gt2100;
	logic               le1900;
	logic [6:0]         c100m;
	logic [6:0]         corr_a;
	logic [6:0]         ceil_c;
	logic [6:0]         ceil_4;
	logic [6:0]         corr_b;
	logic signed [7:0]  corr_d;
	logic               leap;
	logic [8:0]         doy_d;
	logic signed [11:0] mz;
	logic signed [18:0] sd_d;

	// Stage registers
	logic               v_s1, v_s2, v_s3;
	a2e_pkg::a2e_err_t  code_s1, code_s2, code_s3;
	logic               ge_s1, ge_s2, ge_s3;
	logic [13:0]        y_s1;
	logic signed [7:0]  corr_s1;
	logic [8:0]         doy_s1;
	logic signed [18:0] sd_s1, sd_s2;
	logic signed [22:0] days_s2;
	logic signed [39:0] secs_s3;

	// Stage 2 and 3 combinational terms
	logic signed [14:0] yd;
	logic [13:0]        qa;
	logic [13:0]        qb;
	logic signed [22:0] qs;
	logic signed [22:0] days_d;
	logic signed [39:0] secs_d;
	a2e_pkg::a2e_err_t  code_fin;

	// Stall all stages while the last one waits on a full result queue
	assign en       = !v_s3 || !out_full;
	assign job_pop  = en && job_valid;
	assign res_push = v_s3 && !out_full;

	// Stage 1: year, century corrections, day of year, time of day
	always_comb begin
		y_d    = 14'(job.cent) * 14'd100 + 14'(job.low);
		ge_d   = (job.cent > 7'd19) || (job.cent == 7'd19 && job.low >= 7'd70);
		gt2100 = (job.cent > 7'd21) || (job.cent == 7'd21 && job.low != 7'd0);
		le1900 = (job.cent < 7'd19) || (job.cent == 7'd19 && job.low == 7'd0);
		c100m  = (job.low == 7'd0) ? job.cent - 7'd1 : job.cent;
		corr_a = c100m - (c100m >> 2) - 7'd15;
		ceil_c = job.cent + 7'((job.low != 7'd0));
		ceil_4 = (ceil_c + 7'd3) >> 2;
		corr_b = 7'd15 - ceil_c + ceil_4;
		if (ge_d) begin
			corr_d = gt2100 ? -$signed({1'b0, corr_a}) : 8'sd0;
		end else begin
			corr_d = le1900 ? $signed({1'b0, corr_b}) : 8'sd0;
		end
		leap   = ((job.low[1:0] == 2'd0) && (job.low != 7'd0)) ||
		         ((job.low == 7'd0) && (job.cent[1:0] == 2'd0));
		doy_d  = a2e_pkg::cum_days(job.month) + 9'((leap && job.month >= 4'd3)) +
		         9'(job.day) - 9'd1;
		mz     = $signed({6'b0, job.minute}) - 12'(job.zone);
		sd_d   = 19'(job.hour) * 19'd3600 + 19'(mz) * 19'd60 + 19'(job.second);
	end

	// Stage 2: whole days since the epoch
	always_comb begin
		yd     = $signed({1'b0, y_s1}) - 15'sd1970;
		qa     = (y_s1 - 14'd1969) >> 2;
		qb     = (14'd1972 - y_s1) >> 2;
		qs     = ge_s1 ? $signed(23'(qa)) : -$signed(23'(qb));
		days_d = 23'(yd) * 23'd365 + qs + 23'(corr_s1) + 23'(doy_s1);
	end

	// Stage 3: seconds
	assign secs_d = 40'(days_s2) * 40'd86400 + 40'(sd_s2);

	// Check the sign against the year side of the epoch
	always_comb begin
		priority if (code_s3 != a2e_pkg::ERR_NONE) begin
			code_fin = code_s3;
		end else if (ge_s3 == secs_s3[39]) begin
			code_fin = a2e_pkg::ERR_RANGE;
		end else begin
			code_fin = a2e_pkg::ERR_NONE;
		end
		result.error_code    = code_fin;
		result.epoch_seconds = (code_fin == a2e_pkg::ERR_NONE) ? secs_s3[38:0] : 39'sd0;
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= job_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			code_s1 <= job.code;
			ge_s1   <= ge_d;
			y_s1    <= y_d;
			corr_s1 <= corr_d;
			doy_s1  <= doy_d;
			sd_s1   <= sd_d;
			code_s2 <= code_s1;
			ge_s2   <= ge_s1;
			days_s2 <= days_d;
			sd_s2   <= sd_s1;
			code_s3 <= code_s2;
			ge_s3   <= ge_s2;
			secs_s3 <= secs_d;
		end
	end

endmodule

// File: rtl/asn1_time_to_epoch.sv
// ----------------------------------------------------------------------------
// asn1_time_to_epoch - ASN.1 UTCTime / GeneralizedTime to Unix seconds
// Scanner front end, job queue, epoch pipeline and result queue.
// ----------------------------------------------------------------------------
// One character is accepted per cycle, every cycle, as long as full is low.
// The scanner checks each field as it arrives; on the final character the
// classified string goes into a job queue of JobDepth entries, and a three
// stage pipeline (calendar terms, day count, seconds) computes the result.
// A string's job is registered in the job queue and in each pipeline stage, and its
// result sits in a queue of ResDepth entries until popped.
// full rises when the job queue holds JobDepth strings that the pipeline has
// not taken, which happens only after a full result queue has stalled the pipeline.
module asn1_time_to_epoch #(
	parameter int JobDepth = 2,
	parameter int ResDepth = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  a2e_pkg::a2e_item_t    item,
	input  logic                  pop,
	output logic                  empty,
	output a2e_pkg::a2e_result_t  result
);

	localparam int JobW = $bits(a2e_pkg::a2e_job_t);
	localparam int ResW = $bits(a2e_pkg::a2e_result_t);

	logic                  take;
	logic                  job_push;
	a2e_pkg::a2e_job_t     job_in;
	a2e_pkg::a2e_job_t     job_out;
	logic                  job_empty;
	logic                  job_pop;
	logic                  res_push;
	logic                  res_full;
	a2e_pkg::a2e_result_t  res_in;

	assign take = push && !full;

	// Scan characters
	a2e_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (item),
		.job_valid (job_push),
		.job       (job_in)
	);

	// Decouple scanner and pipeline
	a2e_queue #(
		.Width (JobW),
		.Depth (JobDepth)
	) u_job_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job_in),
		.rd_en   (job_pop),
		.rd_data (job_out),
		.empty   (job_empty),
		.full    (full)
	);

	// Compute seconds
	a2e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.out_full  (res_full),
		.res_push  (res_push),
		.result    (res_in)
	);

	// Hold results until popped
	a2e_queue #(
		.Width (ResW),
		.Depth (ResDepth)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty),
		.full    (res_full)
	);

endmodule
